/* rtl/core/command_line_tokenizer_unit_defines.svh */
// ----------------------------------------------------------------------------
// command line tokenizer assertion macros
// shared concurrent check forms, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, quiet during reset
`define CLT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication on clk, quiet during reset
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CLT_ASSERT_SAME(lbl, ante, cons, msg)
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// shared constants, codes and types of the command line tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clt_pkg;

    // sizing
    localparam int LINE_BYTES = 256;
    localparam int MAX_TOKENS = 5;
    localparam int NAME_BYTES = 8;

    localparam int POS_W     = $clog2(LINE_BYTES);
    localparam int TOK_IDX_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int TOK_CNT_W = $clog2(MAX_TOKENS + 1);
    localparam int NAME_W    = 8 * NAME_BYTES;
    localparam int NLEN_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    // byte codes
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_FF    = 8'h0C;
    localparam logic [7:0] LEN_MAX    = 8'hFF;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_NAME        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_NAME_LENGTH = 2'd1;
    localparam logic [63:0]          NAME_RESET              = 64'h0000_0000_0044_454C;
    localparam logic [NLEN_W-1:0]    NAME_LENGTH_RESET       = 4'd3;

    // command status codes
    localparam logic [1:0] STATUS_EMPTY     = 2'd0;
    localparam logic [1:0] STATUS_MATCH     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        KIND_ECHO     = 2'd0,
        KIND_OVERFLOW = 2'd1,
        KIND_TOKEN    = 2'd2,
        KIND_END      = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FLUSH = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TOKEN = 2'd2,
        CMD_END   = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic in_full;
        logic is_cr;
        logic out_free;
        logic more_tokens;
    } dp_status_t;

endpackage

/* rtl/core/clt_controller.sv */
// ----------------------------------------------------------------------------
// clt_controller
// sequences byte handling and the token and line-end results of a line
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clt_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  clt_pkg::dp_status_t status,
    output clt_pkg::dp_cmd_t    cmd
);

    clt_pkg::state_t state_reg;
    clt_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = clt_pkg::CMD_NONE;
        case (state_reg)
            clt_pkg::ST_IDLE:
            begin
                if (status.in_full && status.out_free)
                begin
                    if (!status.is_cr)
                    begin
                        cmd.op = clt_pkg::CMD_BYTE;
                    end
                    else if (status.more_tokens)
                    begin
                        cmd.op     = clt_pkg::CMD_TOKEN;
                        state_next = clt_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        cmd.op = clt_pkg::CMD_END;
                    end
                end
            end
            clt_pkg::ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    if (status.more_tokens)
                    begin
                        cmd.op = clt_pkg::CMD_TOKEN;
                    end
                    else
                    begin
                        cmd.op     = clt_pkg::CMD_END;
                        state_next = clt_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = clt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/clt_datapath.sv */
// ----------------------------------------------------------------------------
// clt_datapath
// request buffer, line and token state, name match and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clt_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         kind,
    output logic [7:0]                         echo_byte,
    output logic [2:0]                         token_index,
    output logic [7:0]                         token_start,
    output logic [7:0]                         token_length,
    output logic [2:0]                         token_count,
    output logic                               too_many_tokens,
    output logic [1:0]                         command_status,
    output logic                               last,
    input  logic                               cfg_we,
    input  logic [clt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clt_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  clt_pkg::dp_cmd_t                   cmd,
    output clt_pkg::dp_status_t                status
);

    // configuration
    logic [clt_pkg::NAME_W-1:0]    name_reg;
    logic [clt_pkg::NLEN_W-1:0]    name_len_reg;

    // request buffer
    logic                          in_full_reg;
    logic                          in_full_next;
    logic [7:0]                    in_byte_reg;

    // line state
    logic [clt_pkg::POS_W-1:0]     pos_reg;
    logic [clt_pkg::POS_W-1:0]     pos_next;
    logic                          inside_reg;
    logic                          inside_next;
    logic [clt_pkg::TOK_CNT_W-1:0] seen_reg;
    logic [clt_pkg::TOK_CNT_W-1:0] seen_next;
    logic                          tok_ovf_reg;
    logic                          tok_ovf_next;
    logic                          match_reg;
    logic                          match_next;
    logic [7:0]                    cur_len_reg;
    logic [7:0]                    cur_len_next;
    logic [clt_pkg::TOK_CNT_W-1:0] idx_reg;
    logic [clt_pkg::TOK_CNT_W-1:0] idx_next;

    // token store, undefined until written
    logic [7:0]                    starts_reg [clt_pkg::MAX_TOKENS];
    logic [7:0]                    lengths_reg [clt_pkg::MAX_TOKENS];
    logic                          start_we;
    logic                          len_we;
    logic [clt_pkg::TOK_IDX_W-1:0] start_addr;
    logic [clt_pkg::TOK_IDX_W-1:0] len_addr;
    logic [7:0]                    start_wdata;
    logic [7:0]                    len_wdata;
    logic [clt_pkg::TOK_IDX_W-1:0] rd_addr;
    logic [clt_pkg::TOK_CNT_W-1:0] seen_minus;

    // result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_load;
    clt_pkg::kind_t                kind_reg;
    clt_pkg::kind_t                kind_next;
    logic [7:0]                    echo_reg;
    logic [7:0]                    echo_next;
    logic [2:0]                    tidx_reg;
    logic [2:0]                    tidx_next;
    logic [7:0]                    tstart_reg;
    logic [7:0]                    tstart_next;
    logic [7:0]                    tlen_reg;
    logic [7:0]                    tlen_next;
    logic [2:0]                    tcount_reg;
    logic [2:0]                    tcount_next;
    logic                          many_reg;
    logic                          many_next;
    logic [1:0]                    cstat_reg;
    logic [1:0]                    cstat_next;
    logic                          last_reg;
    logic                          last_next;

    logic                          pop;
    logic                          blank;
    logic                          byte_match;
    logic [7:0]                    match_pos;
    logic [clt_pkg::NLEN_W-1:0]    name_n;

    // whitespace test
    function automatic logic is_blank(input logic [7:0] b);
        logic r;
        r = (b == clt_pkg::BYTE_SPACE) || ((b >= clt_pkg::BYTE_TAB) && (b <= clt_pkg::BYTE_FF));
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_reg     <= clt_pkg::NAME_RESET;
            name_len_reg <= clt_pkg::NAME_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                clt_pkg::CFG_COMMAND_NAME:
                begin
                    name_reg <= cfg_data[clt_pkg::NAME_W-1:0];
                end
                clt_pkg::CFG_COMMAND_NAME_LENGTH:
                begin
                    name_len_reg <= cfg_data[clt_pkg::NLEN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // status to the controller
    assign in_ready           = !in_full_reg;
    assign status.in_full     = in_full_reg;
    assign status.is_cr       = (in_byte_reg == clt_pkg::BYTE_CR);
    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.more_tokens = (idx_reg < seen_reg);

    // name byte compare at the current token offset
    assign name_n     = (name_len_reg > clt_pkg::NLEN_W'(clt_pkg::NAME_BYTES))
                        ? clt_pkg::NLEN_W'(clt_pkg::NAME_BYTES) : name_len_reg;
    assign byte_match = ({4'd0, match_pos} < {8'd0, name_n})
                        && (name_reg[8 * match_pos[2:0] +: 8] == in_byte_reg);
    assign blank      = is_blank(in_byte_reg);
    assign seen_minus = seen_reg - clt_pkg::TOK_CNT_W'(1);
    assign rd_addr    = idx_reg[clt_pkg::TOK_IDX_W-1:0];

    // line, token and result next values
    always_comb
    begin
        pos_next     = pos_reg;
        inside_next  = inside_reg;
        seen_next    = seen_reg;
        tok_ovf_next = tok_ovf_reg;
        match_next   = match_reg;
        cur_len_next = cur_len_reg;
        idx_next     = idx_reg;
        start_we     = 1'b0;
        len_we       = 1'b0;
        start_addr   = seen_reg[clt_pkg::TOK_IDX_W-1:0];
        len_addr     = seen_reg[clt_pkg::TOK_IDX_W-1:0];
        start_wdata  = 8'(pos_reg);
        len_wdata    = 8'd1;
        match_pos    = 8'd0;
        pop          = 1'b0;
        out_load     = 1'b0;
        kind_next    = clt_pkg::KIND_ECHO;
        echo_next    = 8'd0;
        tidx_next    = 3'd0;
        tstart_next  = 8'd0;
        tlen_next    = 8'd0;
        tcount_next  = 3'd0;
        many_next    = 1'b0;
        cstat_next   = clt_pkg::STATUS_EMPTY;
        last_next    = 1'b0;
        case (cmd.op)
            clt_pkg::CMD_BYTE:
            begin
                pop       = 1'b1;
                out_load  = 1'b1;
                echo_next = in_byte_reg;
                last_next = 1'b1;
                if (pos_reg == clt_pkg::POS_W'(clt_pkg::LINE_BYTES - 1))
                begin
                    // line overflow drops the byte and restarts the line
                    kind_next    = clt_pkg::KIND_OVERFLOW;
                    pos_next     = '0;
                    inside_next  = 1'b0;
                    seen_next    = '0;
                    tok_ovf_next = 1'b0;
                    match_next   = 1'b1;
                end
                else
                begin
                    kind_next = clt_pkg::KIND_ECHO;
                    pos_next  = pos_reg + clt_pkg::POS_W'(1);
                    if (blank)
                    begin
                        inside_next = 1'b0;
                    end
                    else if (!inside_reg)
                    begin
                        // start of a token
                        inside_next = 1'b1;
                        if (seen_reg < clt_pkg::TOK_CNT_W'(clt_pkg::MAX_TOKENS))
                        begin
                            start_we     = 1'b1;
                            len_we       = 1'b1;
                            cur_len_next = 8'd1;
                            if ((seen_reg == '0) && !byte_match)
                            begin
                                match_next = 1'b0;
                            end
                            seen_next = seen_reg + clt_pkg::TOK_CNT_W'(1);
                        end
                        else
                        begin
                            tok_ovf_next = 1'b1;
                        end
                    end
                    else if (!tok_ovf_reg && (seen_reg != '0))
                    begin
                        // token grows by one byte, saturating at LEN_MAX
                        match_pos = cur_len_reg;
                        len_addr  = seen_minus[clt_pkg::TOK_IDX_W-1:0];
                        if ((seen_reg == clt_pkg::TOK_CNT_W'(1)) && !byte_match)
                        begin
                            match_next = 1'b0;
                        end
                        if (cur_len_reg < clt_pkg::LEN_MAX)
                        begin
                            cur_len_next = cur_len_reg + 8'd1;
                            len_we       = 1'b1;
                            len_wdata    = cur_len_reg + 8'd1;
                        end
                    end
                end
            end
            clt_pkg::CMD_TOKEN:
            begin
                out_load    = 1'b1;
                kind_next   = clt_pkg::KIND_TOKEN;
                tidx_next   = 3'(idx_reg);
                tstart_next = starts_reg[rd_addr];
                tlen_next   = lengths_reg[rd_addr];
                idx_next    = idx_reg + clt_pkg::TOK_CNT_W'(1);
            end
            clt_pkg::CMD_END:
            begin
                pop         = 1'b1;
                out_load    = 1'b1;
                kind_next   = clt_pkg::KIND_END;
                tcount_next = 3'(seen_reg);
                many_next   = tok_ovf_reg;
                last_next   = 1'b1;
                if (seen_reg == '0)
                begin
                    cstat_next = clt_pkg::STATUS_EMPTY;
                end
                else if (match_reg)
                begin
                    cstat_next = clt_pkg::STATUS_MATCH;
                end
                else
                begin
                    cstat_next = clt_pkg::STATUS_NOT_FOUND;
                end
                pos_next     = '0;
                inside_next  = 1'b0;
                seen_next    = '0;
                tok_ovf_next = 1'b0;
                match_next   = 1'b1;
                idx_next     = '0;
            end
            default:
            begin
            end
        endcase
    end

    // buffer and result valid next values
    always_comb
    begin
        in_full_next = in_full_reg;
        if (pop)
        begin
            in_full_next = 1'b0;
        end
        else if (in_valid && !in_full_reg)
        begin
            in_full_next = 1'b1;
        end
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            inside_reg    <= 1'b0;
            seen_reg      <= '0;
            tok_ovf_reg   <= 1'b0;
            match_reg     <= 1'b1;
            idx_reg       <= '0;
            cur_len_reg   <= 8'd0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            inside_reg    <= inside_next;
            seen_reg      <= seen_next;
            tok_ovf_reg   <= tok_ovf_next;
            match_reg     <= match_next;
            idx_reg       <= idx_next;
            cur_len_reg   <= cur_len_next;
        end
    end

    // payload registers and token store
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_full_reg)
        begin
            in_byte_reg <= rx_byte;
        end
        if (start_we)
        begin
            starts_reg[start_addr] <= start_wdata;
        end
        if (len_we)
        begin
            lengths_reg[len_addr] <= len_wdata;
        end
        if (out_load)
        begin
            kind_reg   <= kind_next;
            echo_reg   <= echo_next;
            tidx_reg   <= tidx_next;
            tstart_reg <= tstart_next;
            tlen_reg   <= tlen_next;
            tcount_reg <= tcount_next;
            many_reg   <= many_next;
            cstat_reg  <= cstat_next;
            last_reg   <= last_next;
        end
    end

    // result ports
    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign echo_byte       = echo_reg;
    assign token_index     = tidx_reg;
    assign token_start     = tstart_reg;
    assign token_length    = tlen_reg;
    assign token_count     = tcount_reg;
    assign too_many_tokens = many_reg;
    assign command_status  = cstat_reg;
    assign last            = last_reg;

endmodule

/* rtl/core/command_line_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// console line tokenizer with echo, token descriptors and command match
// ----------------------------------------------------------------------------
// Each received byte is taken into a one-entry request buffer and handled in
// the next free cycle of the result register: an ordinary byte gives one echo
// result, which passes through the request buffer and then the result
// register, and a carriage return gives one token descriptor per kept token
// followed by a line-end result, one per cycle while the consumer holds ready
// high, so a line with five tokens ends in six results. The buffer refills only
// after the byte it holds has been fully handled, so no new byte is taken
// while an echo or a line end is still pending, also while the consumer holds
// ready low. Token starts and lengths are kept in a five-entry register store;
// the name compare runs byte by byte as the first token arrives.
`timescale 1ns / 1ps

`include "command_line_tokenizer_unit_defines.svh"

module command_line_tokenizer_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     kind,
    output logic [7:0]                     echo_byte,
    output logic [2:0]                     token_index,
    output logic [7:0]                     token_start,
    output logic [7:0]                     token_length,
    output logic [2:0]                     token_count,
    output logic                           too_many_tokens,
    output logic [1:0]                     command_status,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [clt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clt_pkg::CFG_DATA_W-1:0] cfg_data
);

    clt_pkg::dp_cmd_t    cmd;
    clt_pkg::dp_status_t status;

    // sequencer
    clt_controller u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // line state and results
    clt_datapath u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .echo_byte       (echo_byte),
        .token_index     (token_index),
        .token_start     (token_start),
        .token_length    (token_length),
        .token_count     (token_count),
        .too_many_tokens (too_many_tokens),
        .command_status  (command_status),
        .last            (last),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status)
    );

    // checks
    `CLT_ASSERT_NEXT(a_buffer_fills, in_valid && in_ready, !in_ready, "request buffer did not fill")
    `CLT_ASSERT_SAME(a_cr_held, out_valid && (kind == clt_pkg::KIND_TOKEN), !in_ready, "carriage return left buffer before line end")
    `CLT_ASSERT_SAME(a_token_not_last, out_valid && (kind == clt_pkg::KIND_TOKEN), !last && (token_index < 3'(clt_pkg::MAX_TOKENS)), "bad token descriptor")

endmodule
